/* hw/rtl/mwprng_pkg.sv */
package mwprng_pkg;

   // state word and result width
   localparam int WORD_BITS = 64;
   localparam int SEED_COUNT = 6;
   localparam int REQ_DATA_BITS = WORD_BITS * SEED_COUNT;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [1:0] mode_type;
   typedef logic [0:0] op_type;

   // width modes
   localparam mode_type MODE_W8  = 2'd0;
   localparam mode_type MODE_W16 = 2'd1;
   localparam mode_type MODE_W32 = 2'd2;
   localparam mode_type MODE_W64 = 2'd3;
   localparam mode_type MODE_RESET = MODE_W64;

   // request kinds
   localparam op_type OP_DRAW = 1'b0;
   localparam op_type OP_LOAD = 1'b1;

   // per-width increment constants
   localparam word_type ADD_W8  = 64'd111;
   localparam word_type ADD_W16 = 64'd1111;
   localparam word_type ADD_W32 = 64'd111111111;
   localparam word_type ADD_W64 = 64'd111111111111111111;

   // mask of the live bits for a width mode
   function automatic word_type width_mask(mode_type mode);
      word_type m;
      case (mode)
         MODE_W8:  m = 64'h0000_0000_0000_00ff;
         MODE_W16: m = 64'h0000_0000_0000_ffff;
         MODE_W32: m = 64'h0000_0000_ffff_ffff;
         default:  m = 64'hffff_ffff_ffff_ffff;
      endcase
      return m;
   endfunction

   // increment constant for a width mode
   function automatic word_type width_add(mode_type mode);
      word_type k;
      case (mode)
         MODE_W8:  k = ADD_W8;
         MODE_W16: k = ADD_W16;
         MODE_W32: k = ADD_W32;
         default:  k = ADD_W64;
      endcase
      return k;
   endfunction

   // rotate left within the word width: 3, 6, 13 or 25 bits
   function automatic word_type rotate_word(mode_type mode, word_type d);
      word_type r;
      case (mode)
         MODE_W8:  r = {56'd0, d[4:0], d[7:5]};
         MODE_W16: r = {48'd0, d[9:0], d[15:10]};
         MODE_W32: r = {32'd0, d[18:0], d[31:19]};
         default:  r = {d[38:0], d[63:39]};
      endcase
      return r;
   endfunction

endpackage

/* hw/rtl/multi_width_lagged_add_xor_prng_core.sv */
// six-word lagged add/xor random generator, word width 8, 16, 32 or 64 bits
// a draw request gives its value in the cycle after it is accepted
// throughput: one request per cycle unless the output stalls; the state update
// is one add/rotate/xor pass; a load request updates the state words and gives
// no value; reset (synchronous, active high) clears all state words, selects
// 64-bit mode and empties the output register
module multi_width_lagged_add_xor_prng_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration: width_mode
   input  logic                                 csr_wr_en,
   input  mwprng_pkg::mode_type                 csr_wr_data,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // seed_a, seed_b, seed_c, seed_d, seed_e, seed_f (64 bits each, low to high)
   input  logic [mwprng_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // operation
   input  mwprng_pkg::op_type                   req_tuser,
   // result channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // random_value
   output mwprng_pkg::word_type                 rsp_tdata
);
   import mwprng_pkg::*;

   mode_type width_mode_ff;
   word_type word_a_ff, word_b_ff, word_c_ff, word_d_ff, word_e_ff, word_f_ff;
   word_type word_a_in, word_b_in, word_c_in, word_d_in, word_e_in, word_f_in;
   logic     rsp_valid_ff, rsp_valid_in;
   word_type rsp_data_ff, rsp_data_in;

   logic     req_fire;
   word_type mask;
   word_type cur_a, cur_b, cur_c, cur_d, cur_e, cur_f;
   word_type mix, next_a, next_b, next_e, next_f;
   word_type value;

   // take a request whenever the output register is free or being emptied
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   // draw datapath on the masked current state
   always_comb begin
      mask   = width_mask(width_mode_ff);
      cur_a  = word_a_ff & mask;
      cur_b  = word_b_ff & mask;
      cur_c  = word_c_ff & mask;
      cur_d  = word_d_ff & mask;
      cur_e  = word_e_ff & mask;
      cur_f  = word_f_ff & mask;
      mix    = rotate_word(width_mode_ff, cur_d);
      next_f = (cur_f + cur_e) & mask;
      next_e = (cur_e + cur_b) & mask;
      next_b = (cur_a + width_add(width_mode_ff)) & mask;
      next_a = (next_f ^ mix) & mask;
      value  = (next_a ^ (next_b >> 1)) & mask;
   end

   // next state: load seeds or advance the lagged words
   always_comb begin
      word_a_in = word_a_ff;
      word_b_in = word_b_ff;
      word_c_in = word_c_ff;
      word_d_in = word_d_ff;
      word_e_in = word_e_ff;
      word_f_in = word_f_ff;
      if (req_fire) begin
         if (req_tuser == OP_LOAD) begin
            word_a_in = req_tdata[0*WORD_BITS +: WORD_BITS] & mask;
            word_b_in = req_tdata[1*WORD_BITS +: WORD_BITS] & mask;
            word_c_in = req_tdata[2*WORD_BITS +: WORD_BITS] & mask;
            word_d_in = req_tdata[3*WORD_BITS +: WORD_BITS] & mask;
            word_e_in = req_tdata[4*WORD_BITS +: WORD_BITS] & mask;
            word_f_in = req_tdata[5*WORD_BITS +: WORD_BITS] & mask;
         end else begin
            word_a_in = next_a;
            word_b_in = next_b;
            word_c_in = cur_b;
            word_d_in = cur_c;
            word_e_in = next_e;
            word_f_in = next_f;
         end
      end
   end

   // output register control
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (req_fire && req_tuser == OP_DRAW) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = value;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_mode_ff <= MODE_RESET;
         word_a_ff     <= '0;
         word_b_ff     <= '0;
         word_c_ff     <= '0;
         word_d_ff     <= '0;
         word_e_ff     <= '0;
         word_f_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            width_mode_ff <= csr_wr_data;
         end
         word_a_ff    <= word_a_in;
         word_b_ff    <= word_b_in;
         word_c_ff    <= word_c_in;
         word_d_ff    <= word_d_in;
         word_e_ff    <= word_e_in;
         word_f_ff    <= word_f_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* hw/rtl/mwprng_checker.sv */
module mwprng_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input mwprng_pkg::op_type   req_tuser,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input mwprng_pkg::word_type rsp_tdata
);
   import mwprng_pkg::*;

   // output is empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   // requests are taken whenever the output is not stalled
   a_req_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("request refused while output free");

   // every accepted draw request shows a result next cycle
   a_draw_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == OP_DRAW |=> rsp_tvalid)
      else $error("draw request gave no result");

   // a load request with nothing pending leaves the output empty
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == OP_LOAD && !(rsp_tvalid && !rsp_tready)
      |=> !rsp_tvalid)
      else $error("load request produced a result");

endmodule

bind multi_width_lagged_add_xor_prng_core mwprng_checker u_mwprng_checker (.*);
